>>> sv/sorted_delay_list_assert.svh
// Assertion macros used by the sorted delay list top level.
`ifndef SORTED_DELAY_LIST_ASSERT_SVH
`define SORTED_DELAY_LIST_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SDL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: cond");

// A condition that must hold in the same cycle as its trigger.
`define SDL_ASSERT_IMP(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed: trig implies cond");

// A condition that must hold in the cycle after its trigger.
`define SDL_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed: trig then cond");

`endif

>>> sv/sdl_pkg.sv
// Package with the sizes, codes and control types of the sorted delay list.
package sdl_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 32;
  localparam int ID_BITS  = 8;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_SORTED = 2'd0,
    MODE_TAIL   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_DUP     = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_CMP  = 2'd1,
    FSM_APP  = 2'd2
  } fsm_t;

  // Operation broadcast to every cell.
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_CMP  = 3'd1,
    OP_INS  = 3'd2,
    OP_REM  = 3'd3,
    OP_CLR  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     sorted;
  } cell_ctrl_t;

endpackage

>>> sv/sdl_cell.sv
// One cell of the list: holds a single entry and shifts with its neighbours.
module sdl_cell
  import sdl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  logic [ID_BITS-1:0]  req_id,
  input  logic [KEY_BITS-1:0] req_key,
  input  logic                after_in,
  output logic                after_out,
  input  logic                left_valid,
  input  logic [ID_BITS-1:0]  left_id,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic                right_valid,
  input  logic [ID_BITS-1:0]  right_id,
  input  logic [KEY_BITS-1:0] right_key,
  output logic                valid_o,
  output logic [ID_BITS-1:0]  id_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic                match_o
);

  logic                valid_r, valid_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                match_r, match_nxt;
  logic                gt_r, gt_nxt;
  logic                flag;
  logic                after;

  // This cell lies at or beyond the insertion point or the removed entry.
  always_comb begin
    if (ctrl.op == OP_REM) begin
      flag = match_r;
    end else begin
      flag = ctrl.sorted & gt_r;
    end
    after = after_in | flag | ((ctrl.op == OP_INS) & ~valid_r);
  end

  assign after_out = after;

  // Compare flags are captured once, then the cell loads, shifts, clears or holds.
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    key_nxt   = key_r;
    match_nxt = match_r;
    gt_nxt    = gt_r;
    case (ctrl.op)
      OP_CMP: begin
        match_nxt = valid_r & (id_r == req_id);
        gt_nxt    = valid_r & (key_r > req_key);
      end
      OP_INS: begin
        if (after) begin
          if (!after_in) begin
            valid_nxt = 1'b1;
            id_nxt    = req_id;
            key_nxt   = req_key;
          end else begin
            valid_nxt = left_valid;
            id_nxt    = left_id;
            key_nxt   = left_key;
          end
        end
      end
      OP_REM: begin
        if (after) begin
          valid_nxt = right_valid;
          id_nxt    = right_id;
          key_nxt   = right_key;
        end
      end
      OP_CLR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      gt_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
      gt_r    <= gt_nxt;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    key_r <= key_nxt;
  end

  assign valid_o = valid_r;
  assign id_o    = id_r;
  assign key_o   = key_r;
  assign match_o = match_r;

endmodule

>>> sv/sorted_delay_list.sv
// Top level of the sorted delay list: sequencer, count and the row of cells.
//
//   Channel  Ports                                       Handshake
//   request  in_mode, in_item_id, in_item_key            start high, busy low
//   result   out_status, out_count, out_head_valid,      out_valid for one cycle
//            out_head_id, out_head_key
//
// A request passes through the accept state, a compare state in which every cell
// matches the id and compares the key, and a shift state in which the cells move.
// The result strobe comes in the cycle after the shift; a new request may be
// accepted in that same cycle. busy is high during the compare and shift states.
// Synchronous reset empties the list and clears the strobe; the receiver
// cannot stall, so results are never held back.
`include "sorted_delay_list_assert.svh"

module sorted_delay_list
  import sdl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [ID_BITS-1:0]  in_item_id,
  input  logic [KEY_BITS-1:0] in_item_key,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [CNT_BITS-1:0] out_count,
  output logic                out_head_valid,
  output logic [ID_BITS-1:0]  out_head_id,
  output logic [KEY_BITS-1:0] out_head_key
);

  fsm_t                state_r, state_nxt;
  mode_t               req_mode_r, req_mode_nxt;
  logic [ID_BITS-1:0]  req_id_r, req_id_nxt;
  logic [KEY_BITS-1:0] req_key_r, req_key_nxt;
  status_t             status_r, status_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  cell_ctrl_t          cell_ctrl;

  logic                cell_valid [DEPTH];
  logic [ID_BITS-1:0]  cell_id    [DEPTH];
  logic [KEY_BITS-1:0] cell_key   [DEPTH];
  logic                cell_match [DEPTH];
  logic                lft_valid  [DEPTH];
  logic [ID_BITS-1:0]  lft_id     [DEPTH];
  logic [KEY_BITS-1:0] lft_key    [DEPTH];
  logic                rgt_valid  [DEPTH];
  logic [ID_BITS-1:0]  rgt_id     [DEPTH];
  logic [KEY_BITS-1:0] rgt_key    [DEPTH];
  logic [DEPTH:0]      after_c;
  logic [DEPTH-1:0]    vld_vec;
  logic [DEPTH-1:0]    match_vec;
  logic                found;
  logic                full;

  assign after_c[0] = 1'b0;

  // The row of cells, each wired to its left and right neighbour.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lft_valid[g] = 1'b0;
      assign lft_id[g]    = '0;
      assign lft_key[g]   = '0;
    end else begin : g_mid_l
      assign lft_valid[g] = cell_valid[g-1];
      assign lft_id[g]    = cell_id[g-1];
      assign lft_key[g]   = cell_key[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rgt_valid[g] = 1'b0;
      assign rgt_id[g]    = '0;
      assign rgt_key[g]   = '0;
    end else begin : g_mid_r
      assign rgt_valid[g] = cell_valid[g+1];
      assign rgt_id[g]    = cell_id[g+1];
      assign rgt_key[g]   = cell_key[g+1];
    end

    sdl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl),
      .req_id      (req_id_r),
      .req_key     (req_key_r),
      .after_in    (after_c[g]),
      .after_out   (after_c[g+1]),
      .left_valid  (lft_valid[g]),
      .left_id     (lft_id[g]),
      .left_key    (lft_key[g]),
      .right_valid (rgt_valid[g]),
      .right_id    (rgt_id[g]),
      .right_key   (rgt_key[g]),
      .valid_o     (cell_valid[g]),
      .id_o        (cell_id[g]),
      .key_o       (cell_key[g]),
      .match_o     (cell_match[g])
    );

    assign vld_vec[g]   = cell_valid[g];
    assign match_vec[g] = cell_match[g];
  end

  assign found = |match_vec;
  assign full  = (count_r == CNT_BITS'(DEPTH));

  // Sequencer: accept, compare, then shift and report.
  always_comb begin
    state_nxt        = state_r;
    req_mode_nxt     = req_mode_r;
    req_id_nxt       = req_id_r;
    req_key_nxt      = req_key_r;
    status_nxt       = status_r;
    count_nxt        = count_r;
    out_valid_nxt    = 1'b0;
    cell_ctrl.op     = OP_HOLD;
    cell_ctrl.sorted = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          req_mode_nxt = mode_t'(in_mode);
          req_id_nxt   = in_item_id;
          req_key_nxt  = in_item_key;
          state_nxt    = FSM_CMP;
        end
      end
      FSM_CMP: begin
        cell_ctrl.op = OP_CMP;
        state_nxt    = FSM_APP;
      end
      FSM_APP: begin
        state_nxt     = FSM_IDLE;
        out_valid_nxt = 1'b1;
        status_nxt    = STAT_OK;
        case (req_mode_r)
          MODE_SORTED, MODE_TAIL: begin
            if (found) begin
              status_nxt = STAT_DUP;
            end else if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              cell_ctrl.op     = OP_INS;
              cell_ctrl.sorted = (req_mode_r == MODE_SORTED) && (req_key_r != KEY_MAX);
              count_nxt        = count_r + CNT_BITS'(1);
            end
          end
          MODE_REMOVE: begin
            if (!found) begin
              status_nxt = STAT_MISSING;
            end else begin
              cell_ctrl.op = OP_REM;
              count_nxt    = count_r - CNT_BITS'(1);
            end
          end
          MODE_CLEAR: begin
            cell_ctrl.op = OP_CLR;
            count_nxt    = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STAT_OK;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  // Request payload.
  always_ff @(posedge clk) begin
    req_mode_r <= req_mode_nxt;
    req_id_r   <= req_id_nxt;
    req_key_r  <= req_key_nxt;
  end

  // Result ports: the head is cell zero, shown as zero when the list is empty.
  assign busy           = (state_r != FSM_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_count      = count_r;
  assign out_head_valid = cell_valid[0];
  assign out_head_id    = cell_valid[0] ? cell_id[0] : '0;
  assign out_head_key   = cell_valid[0] ? cell_key[0] : '0;

  // Checks on the sequencer, the count and the packing of the cells.
  `SDL_ASSERT_IMP(a_strobe_after_shift, out_valid_r, $past(state_r) == FSM_APP)
  `SDL_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_BITS'(DEPTH))
  `SDL_ASSERT_ALWAYS(a_cells_packed, ((vld_vec + DEPTH'(1)) & vld_vec) == '0)
  `SDL_ASSERT_ALWAYS(a_count_matches_cells, $countones(vld_vec) == int'(count_r))
  `SDL_ASSERT_NEXT(a_insert_grows, cell_ctrl.op == OP_INS, count_r == $past(count_r) + 1'b1)

endmodule
